[hw/rtl/rxs_pkg.sv]
//------------------------------------------------------------------------------
// rxs_pkg
// Shared widths, record type, sort key and the control/status bundles
// between the sort controller and its datapath.
//------------------------------------------------------------------------------
`default_nettype none

package rxs_pkg;

	localparam int MAX_RECORDS_DEF = 32;

	localparam int ID_W    = 31;
	localparam int YEAR_W  = 12;
	localparam int SCORE_W = 10;
	localparam int SUM_W   = 12;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [YEAR_W-1:0]  year;
		logic [SCORE_W-1:0] math;
		logic [SCORE_W-1:0] physics;
		logic [SCORE_W-1:0] chemistry;
	} record_t;

	// controller -> datapath
	typedef struct packed {
		logic rd_en;        // registered read of the record store
		logic wr_en;        // write to the record store
		logic wr_from_cur;  // write data: 1 = held record, 0 = incoming word
		logic cur_load;     // held record takes the read data
		logic out_load;     // output register takes the read data
		logic out_last;     // marks the final word of the run
		logic out_ovf;      // batch was truncated
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic key_gt;       // key(held) > key(read data)
		logic out_free;     // output register can take a word this cycle
	} dp_status_t;

	// sort key: exact sum of the three scores (max 3069)
	function automatic logic [SUM_W-1:0] key_of(input record_t r);
		logic [SUM_W-1:0] s;
		s = SUM_W'(r.math) + SUM_W'(r.physics) + SUM_W'(r.chemistry);
		return s;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/rxs_datapath.sv]
//------------------------------------------------------------------------------
// rxs_datapath
// Record store (one write, one registered read port), held-record register
// for the exchange pass, key compare, and the output register.
//------------------------------------------------------------------------------
`default_nettype none

module rxs_datapath #(
	parameter int MAX_RECORDS = rxs_pkg::MAX_RECORDS_DEF,
	localparam int AW = $clog2(MAX_RECORDS)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire rxs_pkg::ctl_cmd_t            cmd,
	input  wire logic [AW-1:0]                raddr,
	input  wire logic [AW-1:0]                waddr,
	input  wire logic [rxs_pkg::ID_W-1:0]     student_id,
	input  wire logic [rxs_pkg::YEAR_W-1:0]   birth_year,
	input  wire logic [rxs_pkg::SCORE_W-1:0]  math_score,
	input  wire logic [rxs_pkg::SCORE_W-1:0]  physics_score,
	input  wire logic [rxs_pkg::SCORE_W-1:0]  chemistry_score,
	output rxs_pkg::dp_status_t               status,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [rxs_pkg::ID_W-1:0]          out_id,
	output logic [rxs_pkg::YEAR_W-1:0]        out_year,
	output logic [rxs_pkg::SCORE_W-1:0]       out_math,
	output logic [rxs_pkg::SCORE_W-1:0]       out_physics,
	output logic [rxs_pkg::SCORE_W-1:0]       out_chemistry,
	output logic [rxs_pkg::SUM_W-1:0]         score_sum,
	output logic                              out_last,
	output logic                              overflow_flag
);
	import rxs_pkg::*;

	record_t mem_q [MAX_RECORDS];
	record_t rd_q;
	record_t cur_q;
	record_t in_rec;
	record_t wdata;

	logic             out_valid_q;
	record_t          out_rec_q;
	logic [SUM_W-1:0] out_sum_q;
	logic             out_last_q;
	logic             out_ovf_q;

	always_comb begin
		in_rec.id        = student_id;
		in_rec.year      = birth_year;
		in_rec.math      = math_score;
		in_rec.physics   = physics_score;
		in_rec.chemistry = chemistry_score;
		wdata            = cmd.wr_from_cur ? cur_q : in_rec;
	end

	// record store
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rd_q <= mem_q[raddr];
		end
	end

	// held record of the current exchange pass
	always_ff @(posedge clk) begin
		if (cmd.cur_load) begin
			cur_q <= rd_q;
		end
	end

	assign status.key_gt   = key_of(cur_q) > key_of(rd_q);
	assign status.out_free = !out_valid_q || out_ready;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_rec_q  <= rd_q;
			out_sum_q  <= key_of(rd_q);
			out_last_q <= cmd.out_last;
			out_ovf_q  <= cmd.out_ovf;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_id        = out_rec_q.id;
	assign out_year      = out_rec_q.year;
	assign out_math      = out_rec_q.math;
	assign out_physics   = out_rec_q.physics;
	assign out_chemistry = out_rec_q.chemistry;
	assign score_sum     = out_sum_q;
	assign out_last      = out_last_q;
	assign overflow_flag = out_ovf_q;

	// a full output register is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while full");

endmodule

`default_nettype wire

[hw/rtl/rxs_controller.sv]
//------------------------------------------------------------------------------
// rxs_controller
// Batch fill counter and sequencer for load, exchange sort and emit.
//------------------------------------------------------------------------------
`default_nettype none

module rxs_controller #(
	parameter int MAX_RECORDS = rxs_pkg::MAX_RECORDS_DEF,
	localparam int AW = $clog2(MAX_RECORDS),
	localparam int CW = $clog2(MAX_RECORDS + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 last_in_batch,
	input  wire rxs_pkg::dp_status_t  status,
	output rxs_pkg::ctl_cmd_t         cmd,
	output logic [AW-1:0]             raddr,
	output logic [AW-1:0]             waddr
);
	import rxs_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_START   = 7'b0000010,
		S_LOAD    = 7'b0000100,
		S_SCAN    = 7'b0001000,
		S_NEXT    = 7'b0010000,
		S_EMIT_RD = 7'b0100000,
		S_EMIT_LD = 7'b1000000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic          ovf_q, ovf_d;
	logic [AW-1:0] a_q, a_d;
	logic [AW-1:0] b_q, b_d;
	logic [AW-1:0] k_q, k_d;
	logic [AW-1:0] last_idx;
	logic          has_room;
	logic          in_acc;

	assign last_idx = AW'(count_q - CW'(1));
	assign has_room = count_q < CW'(MAX_RECORDS);
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		ovf_d   = ovf_q;
		a_d     = a_q;
		b_d     = b_q;
		k_d     = k_q;
		cmd     = '0;
		raddr   = '0;
		waddr   = '0;

		unique case (state_q)
			S_IDLE: begin
				waddr = count_q[AW-1:0];
				if (in_acc) begin
					if (has_room) begin
						cmd.wr_en = 1'b1;
						count_d   = count_q + CW'(1);
					end else begin
						ovf_d = 1'b1;
					end
					if (last_in_batch) begin
						state_d = S_START;
					end
				end
			end
			S_START: begin
				k_d = '0;
				if (last_idx == '0) begin
					state_d = S_EMIT_RD;
				end else begin
					cmd.rd_en = 1'b1;
					raddr     = '0;
					a_d       = '0;
					state_d   = S_LOAD;
				end
			end
			S_LOAD: begin
				// read data holds entry a
				cmd.cur_load = 1'b1;
				cmd.rd_en    = 1'b1;
				raddr        = AW'(a_q + AW'(1));
				b_d          = AW'(a_q + AW'(1));
				state_d      = S_SCAN;
			end
			S_SCAN: begin
				// read data holds entry b
				waddr = b_q;
				if (status.key_gt) begin
					cmd.wr_en       = 1'b1;
					cmd.wr_from_cur = 1'b1;
					cmd.cur_load    = 1'b1;
				end
				if (b_q == last_idx) begin
					state_d = S_NEXT;
				end else begin
					cmd.rd_en = 1'b1;
					raddr     = AW'(b_q + AW'(1));
					b_d       = AW'(b_q + AW'(1));
				end
			end
			S_NEXT: begin
				cmd.wr_en       = 1'b1;
				cmd.wr_from_cur = 1'b1;
				waddr           = a_q;
				if (AW'(a_q + AW'(1)) == last_idx) begin
					k_d     = '0;
					state_d = S_EMIT_RD;
				end else begin
					cmd.rd_en = 1'b1;
					raddr     = AW'(a_q + AW'(1));
					a_d       = AW'(a_q + AW'(1));
					state_d   = S_LOAD;
				end
			end
			S_EMIT_RD: begin
				cmd.rd_en = 1'b1;
				raddr     = k_q;
				state_d   = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = (k_q == last_idx);
					cmd.out_ovf  = ovf_q;
					if (k_q == last_idx) begin
						count_d = '0;
						ovf_d   = 1'b0;
						state_d = S_IDLE;
					end else begin
						k_d     = AW'(k_q + AW'(1));
						state_d = S_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
			a_q     <= '0;
			b_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ovf_q   <= ovf_d;
			a_q     <= a_d;
			b_q     <= b_d;
			k_q     <= k_d;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_RECORDS))
		else $error("record count above capacity");

	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (b_q > a_q && b_q <= last_idx))
		else $error("scan index out of order");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && cmd.out_last |=> (state_q == S_IDLE && count_q == '0 && !ovf_q))
		else $error("batch state not cleared after final word");

endmodule

`default_nettype wire

[hw/rtl/record_exchange_sort_by_score_unit.sv]
//------------------------------------------------------------------------------
// record_exchange_sort_by_score_unit
// Collects a batch of records, sorts it ascending by the sum of the three
// scores with an exchange sort, and streams the records out in that order.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------------
//   in       | in_valid / in_ready   | student_id, birth_year, math_score,
//            |                       | physics_score, chemistry_score,
//            |                       | last_in_batch
//   out      | out_valid / out_ready | out_id, out_year, out_math, out_physics,
//            |                       | out_chemistry, score_sum, out_last,
//            |                       | overflow_flag
//
// A batch is loaded at one word per cycle while in_valid is high, sorted
// in place, then read out of the store word by word into the output register.
// The sort is bound by the single read port of the record store: one
// compare-and-exchange per cycle while a scan pass runs.
// in_ready is high only while the batch is being loaded; the last word of a
// run may still sit in the output register while the next batch loads.
// A stall on out_ready holds the emit sequence; nothing is dropped.
// Reset clears the control state only; the store needs no clearing since
// only entries written in the current batch are ever read.
//------------------------------------------------------------------------------
`default_nettype none

module record_exchange_sort_by_score_unit #(
	parameter int MAX_RECORDS = rxs_pkg::MAX_RECORDS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [rxs_pkg::ID_W-1:0]     student_id,
	input  wire logic [rxs_pkg::YEAR_W-1:0]   birth_year,
	input  wire logic [rxs_pkg::SCORE_W-1:0]  math_score,
	input  wire logic [rxs_pkg::SCORE_W-1:0]  physics_score,
	input  wire logic [rxs_pkg::SCORE_W-1:0]  chemistry_score,
	input  wire logic                         last_in_batch,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [rxs_pkg::ID_W-1:0]          out_id,
	output logic [rxs_pkg::YEAR_W-1:0]        out_year,
	output logic [rxs_pkg::SCORE_W-1:0]       out_math,
	output logic [rxs_pkg::SCORE_W-1:0]       out_physics,
	output logic [rxs_pkg::SCORE_W-1:0]       out_chemistry,
	output logic [rxs_pkg::SUM_W-1:0]         score_sum,
	output logic                              out_last,
	output logic                              overflow_flag
);
	import rxs_pkg::*;

	localparam int AW = $clog2(MAX_RECORDS);

	ctl_cmd_t   cmd;
	dp_status_t status;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;

	// sequencer: fill count, sort indices, emit index
	rxs_controller #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_ctl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.last_in_batch (last_in_batch),
		.status        (status),
		.cmd           (cmd),
		.raddr         (raddr),
		.waddr         (waddr)
	);

	// store, held record, key compare, output register
	rxs_datapath #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.raddr           (raddr),
		.waddr           (waddr),
		.student_id      (student_id),
		.birth_year      (birth_year),
		.math_score      (math_score),
		.physics_score   (physics_score),
		.chemistry_score (chemistry_score),
		.status          (status),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_id          (out_id),
		.out_year        (out_year),
		.out_math        (out_math),
		.out_physics     (out_physics),
		.out_chemistry   (out_chemistry),
		.score_sum       (score_sum),
		.out_last        (out_last),
		.overflow_flag   (overflow_flag)
	);

endmodule

`default_nettype wire
